[hdl/spqdk_pkg.sv]
// Shared types and constants for the stable priority queue with decrease-key.
`default_nettype none

package spqdk_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP     = 2'd1,
    OP_UPGRADE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_EMPTY           = 3'd1,
    ST_NOT_MORE_URGENT = 3'd2,
    ST_NOT_FOUND       = 3'd3,
    ST_FULL            = 3'd4
  } status_t;

  // Broadcast command seen by every cell in the row.
  typedef struct packed {
    logic                 write;      // Apply the operation to the cells this cycle.
    op_t                  op;
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] prio;
    logic                 found_any;  // Some held entry carries the key.
  } cell_cmd_t;

  // What one cell hands to its neighbor.
  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] prio;
    logic                 le;         // Held, with a priority equal to or more urgent than the new one.
    logic                 found;      // Key matched at this cell or any cell in front.
  } cell_link_t;

endpackage

`default_nettype wire

[hdl/spqdk_if.sv]
// Valid/ready channel interfaces for the queue's command and result items.
`default_nettype none

interface spqdk_cmd_if import spqdk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [KEY_BITS-1:0]  entry_key;
  logic [PRIO_BITS-1:0] entry_priority;

  modport source (output valid, op, entry_key, entry_priority, input ready);
  modport sink   (input valid, op, entry_key, entry_priority, output ready);
endinterface

interface spqdk_rsp_if import spqdk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_BITS-1:0]  popped_key;
  logic [2:0]           status;
  logic [KEY_BITS-1:0]  head_key;
  logic [PRIO_BITS-1:0] head_priority;
  logic                 is_empty;
  logic [CNT_W-1:0]     fill_count;

  modport source (output valid, popped_key, status, head_key, head_priority, is_empty,
                  fill_count, input ready);
  modport sink   (input valid, popped_key, status, head_key, head_priority, is_empty,
                  fill_count, output ready);
endinterface

`default_nettype wire

[hdl/spqdk_cell.sv]
// One slot of the sorted row: holds an entry and shifts it with its neighbors.
`default_nettype none

module spqdk_cell import spqdk_pkg::*; (
  input  wire logic       clk,
  input  wire cell_cmd_t  cmd,
  input  wire logic       occ,
  input  wire cell_link_t lft,
  input  wire cell_link_t rgt,
  output cell_link_t      link,
  output logic            first_hit
);

  logic [KEY_BITS-1:0]  key;
  logic [PRIO_BITS-1:0] prio;
  logic [KEY_BITS-1:0]  key_next;
  logic [PRIO_BITS-1:0] prio_next;
  logic                 hit;
  logic                 le;
  logic                 in_shift;

  // Local compares against the broadcast key and priority.
  always_comb begin
    hit       = occ && (key == cmd.key);
    le        = occ && (prio <= cmd.prio);
    first_hit = hit && !lft.found;
    link.key   = key;
    link.prio  = prio;
    link.le    = le;
    link.found = lft.found || hit;
  end

  // The upgraded entry moves forward; cells from its new place to its old place shift back.
  assign in_shift = !lft.found && cmd.found_any;

  // Next contents: keep, take the new entry, or take a neighbor's entry.
  always_comb begin
    key_next  = key;
    prio_next = prio;
    case (cmd.op)
      OP_INSERT: begin
        if (!le && lft.le) begin
          key_next  = cmd.key;
          prio_next = cmd.prio;
        end else if (!le) begin
          key_next  = lft.key;
          prio_next = lft.prio;
        end
      end
      OP_POP: begin
        key_next  = rgt.key;
        prio_next = rgt.prio;
      end
      OP_UPGRADE: begin
        if (!le && lft.le) begin
          key_next  = cmd.key;
          prio_next = cmd.prio;
        end else if (!le && in_shift) begin
          key_next  = lft.key;
          prio_next = lft.prio;
        end
      end
      default: begin
        key_next  = key;
        prio_next = prio;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      key  <= key_next;
      prio <= prio_next;
    end
  end

endmodule

`default_nettype wire

[hdl/stable_priority_queue_decrease_key.sv]
// Top level: stable sorted priority queue with decrease-key built as a row of cells.
//
//   Channel  Dir  Fields
//   cmd      in   op, entry_key, entry_priority
//   rsp      out  popped_key, status, head_key, head_priority, is_empty, fill_count
//
// For each command item, every cell compares against the broadcast
// key and priority, the match and placement flags ripple along the row, and all
// cells load their new contents at the same edge. One item per cycle is sustained while results are taken.
// The result waits in an output register; a new command is taken while it is taken.
// Reset empties the queue (fill count zero); cell contents need no reset.
`default_nettype none

module stable_priority_queue_decrease_key import spqdk_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  spqdk_cmd_if.sink  cmd,
  spqdk_rsp_if.source rsp
);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 rsp_valid;
  logic [KEY_BITS-1:0]  popped;
  logic [KEY_BITS-1:0]  popped_next;
  status_t              status;
  status_t              status_next;
  logic                 accept;
  op_t                  op;
  cell_cmd_t            ccmd;
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  first_hit;
  cell_link_t           links [CAPACITY];
  cell_link_t           head_link;
  logic [PRIO_BITS-1:0] hit_prio;

  assign op        = op_t'(cmd.op);
  assign cmd.ready = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  // Occupied cells form a thermometer below the fill count.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = CNT_W'(i) < count;
    end
  end

  // Left edge of the row: always "in front of" any placement, never matched.
  always_comb begin
    head_link       = '0;
    head_link.le    = 1'b1;
    head_link.found = 1'b0;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_link_t lft;
    cell_link_t rgt;
    assign lft = (g == 0) ? head_link : links[(g == 0) ? 0 : g - 1];
    assign rgt = (g == CAPACITY - 1) ? links[g] : links[(g == CAPACITY - 1) ? g : g + 1];
    spqdk_cell u_cell (
      .clk       (clk),
      .cmd       (ccmd),
      .occ       (occ[g]),
      .lft       (lft),
      .rgt       (rgt),
      .link      (links[g]),
      .first_hit (first_hit[g])
    );
  end

  // Priority of the first entry holding the key (one-hot select).
  always_comb begin
    hit_prio = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_prio = hit_prio | (first_hit[i] ? links[i].prio : '0);
    end
  end

  // Status, fill count and popped key for the command item.
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    popped_next = '0;
    case (op)
      OP_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          count_next  = count - 1'b1;
          popped_next = links[0].key;
        end
      end
      OP_UPGRADE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!links[CAPACITY-1].found) begin
          status_next = ST_NOT_FOUND;
        end else if (hit_prio <= cmd.entry_priority) begin
          status_next = ST_NOT_MORE_URGENT;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  // Broadcast command to the row.
  always_comb begin
    ccmd.write     = accept && (status_next == ST_OK) && (op != OP_CLEAR);
    ccmd.op        = op;
    ccmd.key       = cmd.entry_key;
    ccmd.prio      = cmd.entry_priority;
    ccmd.found_any = links[CAPACITY-1].found;
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped <= popped_next;
      status <= status_next;
    end
  end

  // The row only changes when a new result is loaded, so the head reads straight from it.
  assign rsp.valid         = rsp_valid;
  assign rsp.popped_key    = popped;
  assign rsp.status        = status;
  assign rsp.head_key      = (count != '0) ? links[0].key : '0;
  assign rsp.head_priority = (count != '0) ? links[0].prio : '0;
  assign rsp.is_empty      = (count == '0);
  assign rsp.fill_count    = count;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A pop on a non-empty queue removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_POP && count != '0) |=> count == $past(count) - 1'b1)
    else $error("pop did not remove one entry");

  // A refused insert leaves the queue as it was.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_INSERT && count == CNT_W'(CAPACITY)) |=>
      (count == $past(count) && status == ST_FULL))
    else $error("insert into full queue changed the fill count");

  // Only successful operations update the cells.
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    ccmd.write |-> (accept && status_next == ST_OK))
    else $error("cells written on a failed operation");

endmodule

`default_nettype wire
